/* hdl/blr_pkg.sv */
// shared types and microprogram for the line rasterizer
`timescale 1ns / 1ps

package blr_pkg;

    // microprogram step address
    typedef logic [1:0] step_t;

    // datapath operation selected by the control word
    typedef enum logic [1:0] {
        OP_LOAD,
        OP_SWAP,
        OP_INIT,
        OP_EMIT
    } op_t;

    // jump condition, taken to target when true, else fall through to the next step
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_LAST
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    localparam step_t STEP_LOAD = 2'd0;
    localparam step_t STEP_SWAP = 2'd1;
    localparam step_t STEP_INIT = 2'd2;
    localparam step_t STEP_EMIT = 2'd3;

    // control store; the emit step falls through by address wrap back to load
    function automatic ctrl_word_t prog_rom(input step_t addr);
        ctrl_word_t w;
        case (addr)
            STEP_LOAD: w = '{op: OP_LOAD, cond: COND_NEVER,    target: STEP_LOAD};
            STEP_SWAP: w = '{op: OP_SWAP, cond: COND_NEVER,    target: STEP_LOAD};
            STEP_INIT: w = '{op: OP_INIT, cond: COND_NEVER,    target: STEP_LOAD};
            STEP_EMIT: w = '{op: OP_EMIT, cond: COND_NOT_LAST, target: STEP_EMIT};
            default:   w = '{op: OP_LOAD, cond: COND_ALWAYS,   target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

/* hdl/bresenham_line_rasterizer.sv */
// Bresenham line rasterizer: microcoded sequencer and point datapath
`timescale 1ns / 1ps

// A line transfer is taken when the block is in its load step. The three control
// steps (load, steep swap, ordering) come first, then the emit step runs once per
// point, giving one point per cycle while out_ready stays high. A line of major
// length L gives L+1 points. The emit step of the microprogram loop, with its
// single error add and compare, sets that one-point-per-cycle pace. The output
// register lets the last point wait while the next line is loaded.

module bresenham_line_rasterizer #(
    parameter int COORD_BITS = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [7:0]            tile_code,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] point_x,
    output logic [COORD_BITS-1:0] point_y,
    output logic [7:0]            tile_out,
    output logic                  last_point
);

    localparam int ERR_W = COORD_BITS + 3;

    blr_pkg::step_t     upc_reg;
    blr_pkg::step_t     upc_next;
    blr_pkg::ctrl_word_t cw;

    logic [COORD_BITS-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [COORD_BITS-1:0] major_reg, minor_reg, end_reg;
    logic [COORD_BITS-1:0] dmaj_reg, dmin_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [7:0]            tile_reg;
    logic                  steep_reg;
    logic                  inc_reg, dec_reg;
    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] point_x_reg, point_y_reg;
    logic [7:0]            tile_out_reg;
    logic                  last_point_reg;

    logic [COORD_BITS-1:0] adx, ady;
    logic                  steep_now;
    logic                  out_free;
    logic                  emit_fire;
    logic                  stall;
    logic                  is_last;
    logic                  cond_true;
    logic signed [ERR_W-1:0] err_sum;
    logic signed [ERR_W:0]   err_twice;
    logic signed [ERR_W:0]   dmaj_ext;
    logic                  take_step;
    logic signed [ERR_W-1:0] err_next;

    assign cw = blr_pkg::prog_rom(upc_reg);

    assign adx       = (ax_reg > bx_reg) ? ax_reg - bx_reg : bx_reg - ax_reg;
    assign ady       = (ay_reg > by_reg) ? ay_reg - by_reg : by_reg - ay_reg;
    assign steep_now = ady > adx;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit_fire = (cw.op == blr_pkg::OP_EMIT) && out_free;
    assign is_last   = major_reg == end_reg;

    // error update: add minor distance, step minor when twice error reaches dmaj
    assign err_sum   = err_reg + $signed({3'b000, dmin_reg});
    assign err_twice = {err_sum, 1'b0};
    assign dmaj_ext  = $signed({4'b0000, dmaj_reg});
    assign take_step = err_twice >= dmaj_ext;
    assign err_next  = take_step ? err_sum - $signed({3'b000, dmaj_reg}) : err_sum;

    always_comb
    begin
        case (cw.op)
            blr_pkg::OP_LOAD: stall = !in_valid;
            blr_pkg::OP_EMIT: stall = !out_free;
            default:          stall = 1'b0;
        endcase
        case (cw.cond)
            blr_pkg::COND_ALWAYS:   cond_true = 1'b1;
            blr_pkg::COND_NOT_LAST: cond_true = !is_last;
            default:                cond_true = 1'b0;
        endcase
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (cond_true)
        begin
            upc_next = cw.target;
        end
        else
        begin
            upc_next = upc_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= blr_pkg::STEP_LOAD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cw.op)
            blr_pkg::OP_LOAD:
            begin
                if (in_valid)
                begin
                    ax_reg   <= start_x;
                    ay_reg   <= start_y;
                    bx_reg   <= end_x;
                    by_reg   <= end_y;
                    tile_reg <= tile_code;
                end
            end
            blr_pkg::OP_SWAP:
            begin
                steep_reg <= steep_now;
                if (steep_now)
                begin
                    ax_reg <= ay_reg;
                    ay_reg <= ax_reg;
                    bx_reg <= by_reg;
                    by_reg <= bx_reg;
                end
            end
            blr_pkg::OP_INIT:
            begin
                // order so the major coordinate rises
                if (ax_reg > bx_reg)
                begin
                    major_reg <= bx_reg;
                    end_reg   <= ax_reg;
                    minor_reg <= by_reg;
                    inc_reg   <= by_reg < ay_reg;
                    dec_reg   <= by_reg > ay_reg;
                end
                else
                begin
                    major_reg <= ax_reg;
                    end_reg   <= bx_reg;
                    minor_reg <= ay_reg;
                    inc_reg   <= ay_reg < by_reg;
                    dec_reg   <= ay_reg > by_reg;
                end
                dmaj_reg <= adx;
                dmin_reg <= ady;
                err_reg  <= '0;
            end
            blr_pkg::OP_EMIT:
            begin
                if (emit_fire)
                begin
                    point_x_reg    <= steep_reg ? minor_reg : major_reg;
                    point_y_reg    <= steep_reg ? major_reg : minor_reg;
                    tile_out_reg   <= tile_reg;
                    last_point_reg <= is_last;
                    major_reg      <= major_reg + 1'b1;
                    err_reg        <= err_next;
                    if (take_step && inc_reg)
                    begin
                        minor_reg <= minor_reg + 1'b1;
                    end
                    else if (take_step && dec_reg)
                    begin
                        minor_reg <= minor_reg - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready   = cw.op == blr_pkg::OP_LOAD;
    assign out_valid  = out_valid_reg;
    assign point_x    = point_x_reg;
    assign point_y    = point_y_reg;
    assign tile_out   = tile_out_reg;
    assign last_point = last_point_reg;

    // the final point of a line hands control back to the load step
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && is_last) |=> in_ready)
        else $error("sequencer did not return to load after last point");

    // a new line transfer makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again before the line was set up");

    // the walk never passes the far endpoint
    assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == blr_pkg::OP_EMIT) |-> (major_reg <= end_reg))
        else $error("major coordinate ran past the endpoint");

    // the steep swap leaves the minor distance no larger than the major one
    assert property (@(posedge clk) disable iff (!rst_n)
        (cw.op == blr_pkg::OP_EMIT) |-> (dmin_reg <= dmaj_reg))
        else $error("minor distance exceeds major distance");

endmodule

/* tb/tb_bresenham_line_rasterizer.sv */
// testbench for the line rasterizer: predicted point runs checked against every output transfer
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;

    localparam int COORD_BITS  = 6;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_TAIL  = 80;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t     x;
        coord_t     y;
        logic [7:0] tile;
        logic       last;
    } line_point_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    coord_t     start_x = '0;
    coord_t     start_y = '0;
    coord_t     end_x = '0;
    coord_t     end_y = '0;
    logic [7:0] tile_code = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    coord_t     point_x;
    coord_t     point_y;
    logic [7:0] tile_out;
    logic       last_point;

    line_point_t expected_points[$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    int          ready_hold = 0;
    bit          burst_mode = 1'b0;

    bresenham_line_rasterizer #(
        .COORD_BITS(COORD_BITS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .tile_code (tile_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .point_x   (point_x),
        .point_y   (point_y),
        .tile_out  (tile_out),
        .last_point(last_point)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // mostly no gap, some short, a few long
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic int abs_dist(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // append the points of one line, in order of rising major coordinate
    task automatic rasterize_line(input coord_t sx, input coord_t sy,
                                  input coord_t ex, input coord_t ey,
                                  input logic [7:0] tile);
        int          ax, ay, bx, by, t;
        int          dmaj, dmin, dir, err, minor;
        bit          steep;
        line_point_t p;
        ax = int'(sx);
        ay = int'(sy);
        bx = int'(ex);
        by = int'(ey);
        steep = abs_dist(by, ay) > abs_dist(bx, ax);
        if (steep)
        begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx)
        begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        dmaj  = bx - ax;
        dmin  = abs_dist(by, ay);
        dir   = (ay < by) ? 1 : ((ay > by) ? -1 : 0);
        err   = 0;
        minor = ay;
        for (int major = ax; major <= bx; major++)
        begin
            p.x    = steep ? coord_t'(minor) : coord_t'(major);
            p.y    = steep ? coord_t'(major) : coord_t'(minor);
            p.tile = tile;
            p.last = (major == bx);
            expected_points.push_back(p);
            err += dmin;
            if (2 * err >= dmaj)
            begin
                minor += dir;
                err   -= dmaj;
            end
        end
    endtask

    // one line transfer; valid stays up across back-to-back items
    task automatic send_line(input coord_t sx, input coord_t sy,
                             input coord_t ex, input coord_t ey,
                             input logic [7:0] tile);
        int gap;
        gap = burst_mode ? 0 : idle_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_x   <= sx;
        start_y   <= sy;
        end_x     <= ex;
        end_y     <= ey;
        tile_code <= tile;
        do
            @(posedge clk);
        while (!in_ready);
        rasterize_line(sx, sy, ex, ey, tile);
    endtask

    task automatic report_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // output side: check every transfer, then pick the next ready value
    always @(posedge clk)
    begin
        line_point_t exp_pt;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t ns: unexpected point, expected none, actual x=%0d y=%0d",
                         $time, point_x, point_y);
                error_count++;
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                report_field("point_x", int'(exp_pt.x), int'(point_x));
                report_field("point_y", int'(exp_pt.y), int'(point_y));
                report_field("tile_out", int'(exp_pt.tile), int'(tile_out));
                report_field("last_point", int'(exp_pt.last), int'(last_point));
            end
        end
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= burst_mode ? 0 : idle_gap();
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic test_directed();
        send_line(6'd5, 6'd5, 6'd5, 6'd5, 8'h00);         // equal endpoints
        send_line(6'd0, 6'd0, 6'd0, 6'd0, 8'hFF);
        send_line(6'd63, 6'd63, 6'd63, 6'd63, 8'h01);
        send_line(6'd0, 6'd0, 6'd63, 6'd0, 8'hFF);        // full horizontal
        send_line(6'd63, 6'd63, 6'd0, 6'd63, 8'h80);      // horizontal, reversed
        send_line(6'd0, 6'd0, 6'd0, 6'd63, 8'hAA);        // full vertical
        send_line(6'd0, 6'd63, 6'd0, 6'd0, 8'h55);        // vertical, reversed
        send_line(6'd0, 6'd0, 6'd63, 6'd63, 8'h7F);       // diagonal tie
        send_line(6'd63, 6'd0, 6'd0, 6'd63, 8'hFE);       // diagonal, falling minor
        send_line(6'd10, 6'd20, 6'd20, 6'd10, 8'h3C);
        send_line(6'd0, 6'd0, 6'd63, 6'd62, 8'hC3);       // just shallow
        send_line(6'd0, 6'd0, 6'd62, 6'd63, 8'h0F);       // just steep
        send_line(6'd40, 6'd10, 6'd10, 6'd50, 8'hF0);     // steep, falling minor
        send_line(6'd50, 6'd2, 6'd3, 6'd9, 8'h12);        // shallow, reversed
        send_line(6'd7, 6'd30, 6'd8, 6'd0, 8'h34);
        send_line(6'd0, 6'd0, 6'd1, 6'd0, 8'h56);
        send_line(6'd1, 6'd1, 6'd0, 6'd0, 8'h78);
        send_line(6'd63, 6'd0, 6'd62, 6'd63, 8'h9A);
        send_line(6'd21, 6'd42, 6'd42, 6'd21, 8'hBC);
    endtask

    task automatic test_random_lines(input int count);
        coord_t sx, sy, ex, ey;
        int     kind;
        for (int i = 0; i < count; i++)
        begin
            sx   = coord_t'($urandom_range(0, COORD_MAX));
            sy   = coord_t'($urandom_range(0, COORD_MAX));
            ex   = coord_t'($urandom_range(0, COORD_MAX));
            ey   = coord_t'($urandom_range(0, COORD_MAX));
            kind = $urandom_range(0, 9);
            case (kind)
                0: ey = sy;                                 // horizontal
                1: ex = sx;                                 // vertical
                2: ey = sy + (ex - sx);                     // diagonal, wraps at the edge
                3: begin ex = sx; ey = sy; end              // single point
                default: ;
            endcase
            send_line(sx, sy, ex, ey, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_short_lines(input int count);
        coord_t sx, sy;
        for (int i = 0; i < count; i++)
        begin
            sx = coord_t'($urandom_range(0, COORD_MAX));
            sy = coord_t'($urandom_range(0, COORD_MAX));
            send_line(sx, sy,
                      sx + coord_t'($urandom_range(0, 6)) - coord_t'(3),
                      sy + coord_t'($urandom_range(0, 6)) - coord_t'(3),
                      8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_back_to_back(input int count);
        burst_mode = 1'b1;
        test_short_lines(count / 2);
        test_random_lines(count - count / 2);
        burst_mode = 1'b0;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_lines(190);
        test_short_lines(70);
        test_back_to_back(50);

        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
